// ===== rtl/pidb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidb_pkg
// Shared widths, register indexes and word types for the PI controller with
// deadband and conditional-integration anti-windup.
// ----------------------------------------------------------------------------
package pidb_pkg;

   // Field widths
   localparam int VAL_W     = 16;             // target, feedback, drive, limits
   localparam int GAIN_W    = 24;             // Q8.16 gains
   localparam int FRAC_W    = 16;             // fractional bits of Q.16 values
   localparam int ERR_W     = VAL_W + 1;      // exact error
   localparam int DB_CMP_W  = VAL_W + 2;      // signed compare against deadband
   localparam int PROD_W    = GAIN_W + ERR_W; // gain * error, exact
   localparam int ACC_W     = 33;             // Q17.16 integral within the limits
   localparam int LIM_W     = VAL_W + FRAC_W; // limit in Q.16
   localparam int SUM_W     = PROD_W + 1;     // product plus integral
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = GAIN_W;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_OUT_UPPER  = 3'd2,
      CSR_OUT_LOWER  = 3'd3,
      CSR_DEAD_BAND  = 3'd4
   } csr_index_type;

   // Reset values
   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 24'sd65536;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 24'sd0;
   localparam logic signed [VAL_W-1:0]  OUT_UPPER_RST  = 16'sh7FFF;
   localparam logic signed [VAL_W-1:0]  OUT_LOWER_RST  = 16'sh8000;
   localparam logic [VAL_W-1:0]         DEAD_BAND_RST  = 16'h0000;

   // Current register settings
   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [VAL_W-1:0]  out_upper;
      logic signed [VAL_W-1:0]  out_lower;
      logic [VAL_W-1:0]         dead_band;
   } cfg_type;

   // Word handed from the multiplier stage to the integrator stage
   typedef struct packed {
      logic                     err_pos;
      logic                     err_neg;
      logic                     in_db;
      logic signed [PROD_W-1:0] pterm;
      logic signed [PROD_W-1:0] iterm;
   } prod_type;

endpackage

// ===== rtl/pidb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidb_if
// Valid/ready channels: request words, response words and register writes.
// ----------------------------------------------------------------------------
interface pidb_req_if;
   import pidb_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] target;
   logic signed [VAL_W-1:0] feedback;
   modport source (output valid, output target, output feedback, input ready);
   modport sink   (input valid, input target, input feedback, output ready);
endinterface

interface pidb_rsp_if;
   import pidb_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] drive;
   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

interface pidb_csr_if;
   import pidb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pidb_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidb_csr
// Gain, limit and deadband registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module pidb_csr (
   input  logic              clock,
   input  logic              reset,
   pidb_csr_if.sink          csr,
   output pidb_pkg::cfg_type cfg
);
   import pidb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write word
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_PROP_GAIN:  cfg_in.prop_gain  = csr.data[GAIN_W-1:0];
            CSR_INTEG_GAIN: cfg_in.integ_gain = csr.data[GAIN_W-1:0];
            CSR_OUT_UPPER:  cfg_in.out_upper  = csr.data[VAL_W-1:0];
            CSR_OUT_LOWER:  cfg_in.out_lower  = csr.data[VAL_W-1:0];
            CSR_DEAD_BAND:  cfg_in.dead_band  = csr.data[VAL_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain  <= PROP_GAIN_RST;
         cfg_ff.integ_gain <= INTEG_GAIN_RST;
         cfg_ff.out_upper  <= OUT_UPPER_RST;
         cfg_ff.out_lower  <= OUT_LOWER_RST;
         cfg_ff.dead_band  <= DEAD_BAND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/pidb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidb_front
// Input register, then error, deadband test and the two gain products into
// the product register.
// ----------------------------------------------------------------------------
module pidb_front (
   input  logic               clock,
   input  logic               reset,
   pidb_req_if.sink           req,
   input  pidb_pkg::cfg_type  cfg,
   output logic               prod_valid,
   input  logic               prod_ready,
   output pidb_pkg::prod_type prod
);
   import pidb_pkg::*;

   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic signed [VAL_W-1:0] target_ff;
   logic signed [VAL_W-1:0] feedback_ff;
   logic                    prod_valid_ff;
   logic                    prod_valid_in;
   prod_type                prod_ff;
   prod_type                prod_in;
   logic                    in_ready;
   logic                    stage_ready;

   logic signed [ERR_W-1:0]    err;
   logic signed [DB_CMP_W-1:0] err_wide;
   logic signed [DB_CMP_W-1:0] db_wide;

   // Advance when the next stage frees up
   assign stage_ready = !prod_valid_ff || prod_ready;
   assign in_ready    = !in_valid_ff || stage_ready;
   assign req.ready   = in_ready;
   assign prod_valid  = prod_valid_ff;
   assign prod        = prod_ff;

   assign in_valid_in   = in_ready ? req.valid : in_valid_ff;
   assign prod_valid_in = stage_ready ? in_valid_ff : prod_valid_ff;

   // Error, deadband test and products
   always_comb begin
      err      = ERR_W'(target_ff) - ERR_W'(feedback_ff);
      err_wide = DB_CMP_W'(err);
      db_wide  = DB_CMP_W'({2'b00, cfg.dead_band});
      prod_in.err_pos = !err[ERR_W-1] && (err != '0);
      prod_in.err_neg = err[ERR_W-1];
      prod_in.in_db   = (err_wide < db_wide) && (err_wide > -db_wide);
      prod_in.pterm   = PROD_W'(cfg.prop_gain) * PROD_W'(err);
      prod_in.iterm   = PROD_W'(cfg.integ_gain) * PROD_W'(err);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   // Hold payload unless a new word moves in
   always_ff @(posedge clock) begin
      if (req.valid && in_ready) begin
         target_ff   <= req.target;
         feedback_ff <= req.feedback;
      end
      if (in_valid_ff && stage_ready) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== rtl/pidb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidb_back
// Integral state, saturation test, conditional integration, output clamp and
// truncation into the response register.
// ----------------------------------------------------------------------------
module pidb_back (
   input  logic               clock,
   input  logic               reset,
   input  pidb_pkg::cfg_type  cfg,
   input  logic               prod_valid,
   output logic               prod_ready,
   input  pidb_pkg::prod_type prod,
   pidb_rsp_if.source         rsp
);
   import pidb_pkg::*;

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [VAL_W-1:0] drive_ff;
   logic signed [VAL_W-1:0] drive_in;
   logic                    take;

   logic signed [LIM_W-1:0] hi_q;
   logic signed [LIM_W-1:0] lo_q;
   logic signed [SUM_W-1:0] hi;
   logic signed [SUM_W-1:0] lo;
   logic signed [SUM_W-1:0] unsat;
   logic signed [SUM_W-1:0] integ_sum;
   logic signed [SUM_W-1:0] integ_clamped;
   logic signed [SUM_W-1:0] out_clamped;
   logic signed [LIM_W-1:0] y_q;
   logic                    sat_hi;
   logic                    sat_lo;
   logic                    integrate;

   // Upper limit first, lower limit second: lower wins when they cross
   function automatic logic signed [SUM_W-1:0] clamp_lim(
      input logic signed [SUM_W-1:0] v,
      input logic signed [SUM_W-1:0] up,
      input logic signed [SUM_W-1:0] dn
   );
      logic signed [SUM_W-1:0] t;
      t = (v > up) ? up : v;
      t = (t < dn) ? dn : t;
      return t;
   endfunction

   assign take       = prod_valid && prod_ready;
   assign prod_ready = !rsp_valid_ff || rsp.ready;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.drive  = drive_ff;

   // Limits in Q.16
   assign hi_q = {cfg.out_upper, {FRAC_W{1'b0}}};
   assign lo_q = {cfg.out_lower, {FRAC_W{1'b0}}};
   assign hi   = SUM_W'(hi_q);
   assign lo   = SUM_W'(lo_q);

   // Integrate unless inside the deadband or winding further into a limit
   always_comb begin
      unsat         = SUM_W'(prod.pterm) + SUM_W'(acc_ff);
      sat_hi        = unsat > hi;
      sat_lo        = unsat < lo;
      integrate     = !prod.in_db && !(sat_hi && prod.err_pos)
                      && !(sat_lo && prod.err_neg);
      integ_sum     = SUM_W'(acc_ff) + SUM_W'(prod.iterm);
      integ_clamped = clamp_lim(integ_sum, hi, lo);
      acc_in        = acc_ff;
      if (take && integrate) begin
         acc_in = integ_clamped[ACC_W-1:0];
      end
   end

   // Output clamp, then truncate toward zero
   always_comb begin
      out_clamped = clamp_lim(SUM_W'(prod.pterm) + SUM_W'(acc_in), hi, lo);
      y_q         = out_clamped[LIM_W-1:0];
      drive_in    = y_q[LIM_W-1:FRAC_W];
      if (y_q[LIM_W-1] && (y_q[FRAC_W-1:0] != '0)) begin
         drive_in = y_q[LIM_W-1:FRAC_W] + VAL_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         drive_ff <= drive_in;
      end
   end

endmodule

// ===== rtl/pi_controller_deadband_antiwindup_unit.sv =====
`timescale 1ns / 1ps
// Path: input register, product register, then response register.
// Throughput: one word per cycle while the receiver is ready; the integral
// update closes in the integrator stage; the gain multipliers sit before it.
// Reset: synchronous, clears the integral to zero, loads register defaults
// and empties all pipeline stages.
// ----------------------------------------------------------------------------
// pi_controller_deadband_antiwindup_unit
// PI controller with deadband and conditional-integration anti-windup.
// ----------------------------------------------------------------------------
module pi_controller_deadband_antiwindup_unit (
   input  logic       clock,
   input  logic       reset,
   pidb_req_if.sink   req,
   pidb_rsp_if.source rsp,
   pidb_csr_if.sink   csr
);
   import pidb_pkg::*;

   cfg_type  cfg;
   logic     prod_valid;
   logic     prod_ready;
   prod_type prod;

   pidb_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   pidb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   pidb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod),
      .rsp        (rsp)
   );

endmodule

// ===== rtl/pidb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidb_checker
// Port-level checks on the PI controller: stalls, latency, word count, reset.
// ----------------------------------------------------------------------------
module pidb_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [pidb_pkg::VAL_W-1:0] rsp_drive
);
   import pidb_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Track words in flight
   always_comb begin
      count_in = count_ff;
      if (req_take && !rsp_take) begin
         count_in = count_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("response dropped or changed while stalled");

   // Accepted word reaches the response valid while the receiver stays ready
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_take && rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("response late");

   // No response without a word in flight
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != 2'd0)
      else $error("response without request");

   // Reset empties the output
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind pi_controller_deadband_antiwindup_unit pidb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_drive (rsp.drive)
);

// ===== test/pidb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidb_scoreboard
// Watches the request, response and register-write channels of the PI
// controller. It keeps its own copy of the gains, limits, deadband and
// integral, predicts each drive word and compares it with the response.
// ----------------------------------------------------------------------------
module pidb_scoreboard (
   input  logic clock,
   input  logic reset,
   pidb_req_if  req,
   pidb_rsp_if  rsp,
   pidb_csr_if  csr,
   output int   fail_count,
   output int   outstanding,
   output int   checked,
   output int   db_holds,
   output int   wind_holds,
   output int   clamped
);
   import pidb_pkg::*;

   localparam longint Q_ONE    = 65536;
   localparam int     SHOW_MAX = 10;

   cfg_type                 cfg;
   logic signed [ACC_W-1:0] integral;
   logic signed [VAL_W-1:0] drive_q[$];
   int                      errors;
   int                      n_checked;
   int                      n_db;
   int                      n_wind;
   int                      n_clamped;

   function automatic longint clamp_q16(input longint v, input longint hi,
                                        input longint lo);
      // upper limit first, lower limit last so it wins when inverted
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   // Advance the integral for one word and return the drive it yields
   function automatic logic signed [VAL_W-1:0] predict_drive(
      input logic signed [VAL_W-1:0] tgt,
      input logic signed [VAL_W-1:0] fbk
   );
      longint err;
      longint hi;
      longint lo;
      longint band;
      longint pterm;
      longint unsat;
      longint acc;
      longint total;
      logic   frozen;
      logic   wind;
      err    = longint'(tgt) - longint'(fbk);
      hi     = longint'(cfg.out_upper) * Q_ONE;
      lo     = longint'(cfg.out_lower) * Q_ONE;
      band   = longint'(cfg.dead_band);
      pterm  = longint'(cfg.prop_gain) * err;
      acc    = longint'(integral);
      unsat  = pterm + acc;
      frozen = (err < band) && (err > -band);
      wind   = (unsat > hi && err > 0) || (unsat < lo && err < 0);
      if (frozen) begin
         n_db++;
      end else if (wind) begin
         n_wind++;
      end else begin
         acc      = clamp_q16(acc + longint'(cfg.integ_gain) * err, hi, lo);
         integral = acc[ACC_W-1:0];
      end
      total = pterm + acc;
      if (total > hi || total < lo) n_clamped++;
      // signed division truncates toward zero
      total = clamp_q16(total, hi, lo) / Q_ONE;
      return total[VAL_W-1:0];
   endfunction

   function automatic void note_failure(input string msg);
      errors++;
      if (errors <= SHOW_MAX) $display("[%0t] ERROR: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin : watch
      logic signed [VAL_W-1:0] want;
      if (reset) begin
         cfg       = '{PROP_GAIN_RST, INTEG_GAIN_RST, OUT_UPPER_RST, OUT_LOWER_RST,
                       DEAD_BAND_RST};
         integral  = '0;
         drive_q.delete();
         errors    = 0;
         n_checked = 0;
         n_db      = 0;
         n_wind    = 0;
         n_clamped = 0;
      end else begin
         // track register writes; spare indexes are dropped
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_PROP_GAIN:  cfg.prop_gain  = csr.data;
               CSR_INTEG_GAIN: cfg.integ_gain = csr.data;
               CSR_OUT_UPPER:  cfg.out_upper  = csr.data[VAL_W-1:0];
               CSR_OUT_LOWER:  cfg.out_lower  = csr.data[VAL_W-1:0];
               CSR_DEAD_BAND:  cfg.dead_band  = csr.data[VAL_W-1:0];
               default: ;
            endcase
         end
         // compare the response word with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            if (drive_q.size() == 0) begin
               note_failure($sformatf("response word with none expected, drive=%0d",
                                      rsp.drive));
            end else begin
               want = drive_q.pop_front();
               n_checked++;
               if (rsp.drive !== want) begin
                  note_failure($sformatf("drive mismatch on word %0d: expected %0d, got %0d",
                                         n_checked, want, rsp.drive));
               end
            end
         end
         // predict the drive for each accepted request word
         if (req.valid && req.ready) begin
            drive_q.push_back(predict_drive(req.target, req.feedback));
         end
      end
      fail_count  <= errors;
      outstanding <= drive_q.size();
      checked     <= n_checked;
      db_holds    <= n_db;
      wind_holds  <= n_wind;
      clamped     <= n_clamped;
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the PI controller: a directed pass over field extremes, the
// deadband edges, windup in both directions and inverted limits, then random
// register settings with tracking, pushing and noise words under bursty
// requests and a stalling receiver. The scoreboard module does the prediction.
// ----------------------------------------------------------------------------
module tb;
   import pidb_pkg::*;

   localparam int RANDOM_WORDS = 1800;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 20;
   localparam int VAL_MAX      = 32767;
   localparam int VAL_MIN      = -32768;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [CSR_DAT_W-1:0] GAIN_ONE = 24'h010000;
   localparam logic [CSR_DAT_W-1:0] GAIN_MIN = 24'h800000;
   localparam logic [CSR_DAT_W-1:0] GAIN_MAX = 24'h7FFFFF;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;
   typedef enum int {GK_FULL, GK_MODEST, GK_FINE, GK_ZERO, GK_EDGE, GK_UNITY} gain_kind_type;
   typedef enum int {WS_NOISE, WS_TRACK, WS_PUSH, WS_EDGE} word_shape_type;

   logic clock;
   logic reset;
   logic rx_ready = 1'b0;

   pidb_req_if req_ch ();
   pidb_rsp_if rsp_ch ();
   pidb_csr_if csr_ch ();

   int fail_count;
   int outstanding;
   int checked;
   int db_holds;
   int wind_holds;
   int clamped;

   int          cycles     = 0;
   int          burst_left = 0;
   int          settings   = 1;
   int          sent       = 0;
   rx_mode_type rx_mode    = RX_OPEN;
   int          rx_left    = 0;
   int          rx_tick    = 0;

   assign rsp_ch.ready = rx_ready;

   pi_controller_deadband_antiwindup_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   pidb_scoreboard u_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr         (csr_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .checked     (checked),
      .db_holds    (db_holds),
      .wind_holds  (wind_holds),
      .clamped     (clamped)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words outstanding",
                  cycles, outstanding);
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver backpressure: switch between randomly chosen stall patterns
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(20, 300);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN:   rx_ready <= 1'b1;
         RX_COIN:   rx_ready <= ($urandom_range(0, 1) == 0);
         RX_SPARSE: rx_ready <= ($urandom_range(0, 7) == 0);
         default:   rx_ready <= ((rx_tick % 5) < 3);
      endcase
   end

   function automatic int rand_val();
      logic signed [VAL_W-1:0] v;
      v = VAL_W'($urandom);
      return int'(v);
   endfunction

   function automatic logic signed [VAL_W-1:0] to_val(input int v);
      if (v > VAL_MAX) v = VAL_MAX;
      if (v < VAL_MIN) v = VAL_MIN;
      return v[VAL_W-1:0];
   endfunction

   function automatic logic [CSR_DAT_W-1:0] rand_gain(input gain_kind_type kind);
      case (kind)
         GK_FULL:   return CSR_DAT_W'($urandom);
         GK_MODEST: return CSR_DAT_W'(int'($urandom_range(0, 24'h60000)) - 24'h30000);
         GK_FINE:   return CSR_DAT_W'(int'($urandom_range(0, 24'h1000)) - 24'h800);
         GK_ZERO:   return '0;
         GK_EDGE:   return ($urandom_range(0, 1) == 0) ? GAIN_MIN : GAIN_MAX;
         default:   return GAIN_ONE;
      endcase
   endfunction

   // Write one register and hold until the channel takes it
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one request word, with a random gap at the start of each burst
   task automatic send_word(input logic signed [VAL_W-1:0] tgt,
                            input logic signed [VAL_W-1:0] fbk);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      burst_left--;
      req_ch.valid    <= 1'b1;
      req_ch.target   <= tgt;
      req_ch.feedback <= fbk;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   // Hold the sender until every predicted word has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      burst_left = 0;
   endtask

   initial begin
      int                      pick;
      int                      up;
      int                      lo;
      int                      db;
      int                      sp;
      int                      bias;
      int                      span;
      int                      err;
      int                      n;
      int                      random_sent;
      word_shape_type          shape;
      logic signed [VAL_W-1:0] tgt;
      logic signed [VAL_W-1:0] fbk;

      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.target   <= '0;
      req_ch.feedback <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= '0;
      csr_ch.data     <= '0;
      random_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: unity gain, no integral, full range, zero deadband
      send_word(16'sh7FFF, 16'sh8000);
      send_word(16'sh8000, 16'sh7FFF);
      send_word(16'sd0, 16'sd0);

      // Narrow limits with a deadband of ten; probe both band edges
      drain();
      write_reg(CSR_PROP_GAIN, GAIN_ONE);
      write_reg(CSR_INTEG_GAIN, GAIN_ONE);
      write_reg(CSR_OUT_UPPER, CSR_DAT_W'(100));
      write_reg(CSR_OUT_LOWER, CSR_DAT_W'(-100));
      write_reg(CSR_DEAD_BAND, CSR_DAT_W'(10));
      write_reg(CSR_SPARE_LO, 24'hFFFFFF);
      settings++;
      send_word(16'sd9, 16'sd0);
      send_word(16'sd0, 16'sd9);
      send_word(16'sd10, 16'sd0);
      send_word(16'sd0, 16'sd10);
      send_word(16'sd0, 16'sd0);
      // Winding high, then winding low
      repeat (3) send_word(16'sd200, 16'sd0);
      repeat (3) send_word(-16'sd200, 16'sd0);

      // Lower limit above upper: the lower clamp wins
      drain();
      write_reg(CSR_OUT_UPPER, CSR_DAT_W'(-50));
      write_reg(CSR_OUT_LOWER, CSR_DAT_W'(50));
      settings++;
      send_word(16'sd0, 16'sd0);
      send_word(16'sd1000, 16'sd0);
      send_word(-16'sd1000, 16'sd0);

      // Extreme gains, full range, widest deadband
      drain();
      write_reg(CSR_PROP_GAIN, GAIN_MIN);
      write_reg(CSR_INTEG_GAIN, GAIN_MAX);
      write_reg(CSR_OUT_UPPER, CSR_DAT_W'(VAL_MAX));
      write_reg(CSR_OUT_LOWER, CSR_DAT_W'(VAL_MIN));
      write_reg(CSR_DEAD_BAND, CSR_DAT_W'(16'hFFFF));
      settings++;
      send_word(16'sh7FFF, 16'sh8000);
      send_word(16'sh8000, 16'sh7FFF);
      send_word(16'sd100, -16'sd100);

      // Opposite extreme gains with the deadband off
      drain();
      write_reg(CSR_PROP_GAIN, GAIN_MAX);
      write_reg(CSR_INTEG_GAIN, GAIN_MIN);
      write_reg(CSR_DEAD_BAND, '0);
      settings++;
      send_word(16'sh7FFF, 16'sh8000);
      send_word(16'sh8000, 16'sh7FFF);
      send_word(16'sd0, 16'sd1);

      // Random settings, each followed by a run of words
      while (random_sent < RANDOM_WORDS) begin
         drain();
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            up = VAL_MAX;
            lo = VAL_MIN;
         end else if (pick < 5) begin
            up = $urandom_range(0, 2000);
            lo = 0 - int'($urandom_range(0, 2000));
         end else if (pick < 6) begin
            lo = int'($urandom_range(0, 3000)) - 1000;
            up = lo - int'($urandom_range(1, 3000));
         end else begin
            up = rand_val();
            lo = rand_val();
            if (lo > up) begin
               n  = up;
               up = lo;
               lo = n;
            end
         end
         pick = $urandom_range(0, 9);
         if (pick < 2) db = 0;
         else if (pick < 5) db = $urandom_range(1, 40);
         else if (pick < 7) db = $urandom_range(41, 3000);
         else if (pick < 8) db = 16'hFFFF;
         else db = $urandom_range(0, 16'hFFFF);
         if ($urandom_range(0, 2) == 0) begin
            write_reg(logic'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)) ?
                      CSR_SPARE_HI : CSR_SPARE_LO, CSR_DAT_W'($urandom));
         end
         write_reg(CSR_PROP_GAIN, rand_gain(gain_kind_type'($urandom_range(0, 5))));
         write_reg(CSR_INTEG_GAIN,
                   rand_gain(($urandom_range(0, 7) == 0) ? GK_FULL :
                             gain_kind_type'($urandom_range(1, 5))));
         write_reg(CSR_OUT_UPPER, CSR_DAT_W'(up));
         write_reg(CSR_OUT_LOWER, CSR_DAT_W'(lo));
         write_reg(CSR_DEAD_BAND, CSR_DAT_W'(db));
         settings++;

         n    = $urandom_range(100, 200);
         sp   = rand_val();
         bias = int'($urandom_range(1, 3000)) * (($urandom_range(0, 1) == 0) ? 1 : -1);
         repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) shape = WS_NOISE;
            else if (pick < 6) shape = WS_TRACK;
            else if (pick < 9) shape = WS_PUSH;
            else shape = WS_EDGE;
            // drift the setpoint and reverse the push now and then to unwind
            if ($urandom_range(0, 29) == 0) sp = rand_val();
            if ($urandom_range(0, 39) == 0) bias = -bias;
            case (shape)
               WS_NOISE: begin
                  tgt = VAL_W'($urandom);
                  fbk = VAL_W'($urandom);
               end
               WS_TRACK: begin
                  span = db + 3;
                  err  = int'($urandom_range(0, 2 * span)) - span;
                  tgt  = to_val(sp);
                  fbk  = to_val(sp - err);
               end
               WS_PUSH: begin
                  err = bias + int'($urandom_range(0, 8)) - 4;
                  tgt = to_val(sp);
                  fbk = to_val(sp - err);
               end
               default: begin
                  tgt = ($urandom_range(0, 1) == 0) ? to_val(VAL_MAX) : to_val(VAL_MIN);
                  fbk = ($urandom_range(0, 1) == 0) ? to_val(rand_val()) : -tgt - 1'b1;
               end
            endcase
            send_word(tgt, fbk);
            random_sent++;
            if ($urandom_range(0, 149) == 0) drain();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d request words over %0d register settings, %0d checked",
               sent, settings, checked);
      $display("Integral held %0d times by deadband, %0d times by windup; %0d clamped",
               db_holds, wind_holds, clamped);
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
